// ===== hw/rtl/gpps_pkg.sv =====
// Shared constants, types and helper functions for the Gaussian elimination solver.
// Used by every module of the solver; depends on nothing.
package gpps_pkg;

    localparam int MAX_N     = 8;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 4;
    localparam int COLS      = MAX_N + 1;
    localparam int DEPTH     = MAX_N * COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_W     = $clog2(MAX_N);
    localparam int CNT_W     = $clog2(MAX_N + 1);
    localparam int DVD_W     = DATA_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DVD_W + 1);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CP_RD,
        ST_CP_WR,
        ST_PV_RD,
        ST_PV_CMP,
        ST_SW_RD,
        ST_SW_W1,
        ST_SW_W2,
        ST_NM_RD,
        ST_NM_PIV,
        ST_NM_KRD,
        ST_NM_GO,
        ST_NM_WAIT,
        ST_EL_F,
        ST_EL_FCAP,
        ST_EL_RD,
        ST_EL_M0,
        ST_EL_M1,
        ST_EL_WR,
        ST_BS_RDB,
        ST_BS_ACC,
        ST_BS_RDJ,
        ST_BS_M0,
        ST_BS_M1,
        ST_BS_UPD,
        ST_OUT
    } state_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] c);
        int a;
        a = int'(r) * COLS + int'(c);
        return ADDR_W'(a);
    endfunction

    function automatic logic [DATA_W:0] mag(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] e;
        e = {v[DATA_W-1], v};
        if (e < 0)
        begin
            e = -e;
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/gauss_partial_pivot_solver.sv =====
// Top level of the Gaussian elimination solver with partial pivoting.
// Holds the matrix memories and the sequencer; uses gpps_pkg, gpps_div, gpps_msub.
//
// Usage:
//   Input channel (in_valid/in_stall): a word with command = load writes one
//   element of the augmented matrix (is_rhs selects the right-hand side). Loads
//   stream back to back while the block is idle. A word with command = solve
//   starts elimination on the first size_in_use rows (0 counts as 1, above 8 as 8).
//   Config channel (cfg_valid/cfg_ready/cfg_data): sets size_in_use (reset 8);
//   write it only while the block is idle.
//   Output channel (out_valid/out_stall): after a solve, one word per unknown
//   in index order, last set on the final word, singular set (values zero)
//   when a zero pivot was met.
// Pivot rows are normalized one element at a time by the shared divider;
//   elimination runs each element through the two-stage multiply-subtract
//   unit. Results then leave one per cycle while out_stall is low.
//   in_stall stays high from the solve word until the last result is taken.
// Reset: asynchronous, returns the sequencer to idle and size_in_use to 8;
//   matrix contents are undefined until loaded. A stalled output word holds.
module gauss_partial_pivot_solver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [2:0]                          row,
    input  logic [2:0]                          column,
    input  logic                                is_rhs,
    input  logic signed [gpps_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          index,
    output logic signed [gpps_pkg::DATA_W-1:0]  solution_value,
    output logic                                singular,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpps_pkg::SIZE_W-1:0]         cfg_data
);
    import gpps_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]        size_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         sel_reg, sel_next;
    logic [DATA_W:0]          best_reg, best_next;
    logic signed [DATA_W-1:0] piv_reg, piv_next;
    logic signed [DATA_W-1:0] f_reg, f_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     sing_reg, sing_next;
    logic signed [DATA_W-1:0] sol_reg  [MAX_N];
    logic signed [DATA_W-1:0] sol_next [MAX_N];

    logic signed [DATA_W-1:0] a_mem [DEPTH];
    logic signed [DATA_W-1:0] w_mem [DEPTH];
    logic signed [DATA_W-1:0] a_rdata_reg;
    logic signed [DATA_W-1:0] w_rdata_a_reg;
    logic signed [DATA_W-1:0] w_rdata_b_reg;
    logic                     a_we;
    logic [ADDR_W-1:0]        a_waddr;
    logic [ADDR_W-1:0]        a_raddr;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic [ADDR_W-1:0]        w_addr_a;
    logic [ADDR_W-1:0]        w_addr_b;

    logic                     div_start;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;
    logic signed [DATA_W-1:0] ms_acc;
    logic signed [DATA_W-1:0] ms_x;
    logic signed [DATA_W-1:0] ms_y;
    logic signed [DATA_W-1:0] ms_res;

    logic [CNT_W-1:0]         n_eff;
    logic [CNT_W-1:0]         n_m1;
    logic [DATA_W:0]          cand;
    logic [DATA_W:0]          new_best;
    logic [CNT_W-1:0]         new_sel;
    logic [ROW_W-1:0]         sol_idx;
    logic                     load_ok;

    gpps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (w_rdata_a_reg),
        .den   (piv_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    gpps_msub u_msub (
        .clk    (clk),
        .acc    (ms_acc),
        .x      (ms_x),
        .y      (ms_y),
        .result (ms_res)
    );

    always_comb
    begin
        if (size_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(size_reg) > MAX_N)
            n_eff = CNT_W'(MAX_N);
        else
            n_eff = CNT_W'(size_reg);
        n_m1     = n_reg - 1'b1;
        cand     = mag(w_rdata_a_reg);
        new_best = (cand > best_reg) ? cand : best_reg;
        new_sel  = (cand > best_reg) ? j_reg : sel_reg;
        sol_idx  = (state_reg == ST_OUT) ? i_reg[ROW_W-1:0] : j_reg[ROW_W-1:0];
        load_ok  = (int'(row) < MAX_N) && (is_rhs || (int'(column) < MAX_N));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && (command == CMD_SOLVE))
                    state_next = ST_CP_RD;
            ST_CP_RD:
                state_next = ST_CP_WR;
            ST_CP_WR:
                if ((k_reg == n_reg) && (j_reg == n_m1))
                    state_next = ST_PV_RD;
                else
                    state_next = ST_CP_RD;
            ST_PV_RD:
                state_next = ST_PV_CMP;
            ST_PV_CMP:
                if (j_reg == n_m1)
                begin
                    if (new_best == '0)
                        state_next = ST_OUT;
                    else if (new_sel != i_reg)
                        state_next = ST_SW_RD;
                    else
                        state_next = ST_NM_RD;
                end
                else
                    state_next = ST_PV_RD;
            ST_SW_RD:
                state_next = ST_SW_W1;
            ST_SW_W1:
                state_next = ST_SW_W2;
            ST_SW_W2:
                state_next = (k_reg == n_reg) ? ST_NM_RD : ST_SW_RD;
            ST_NM_RD:
                state_next = ST_NM_PIV;
            ST_NM_PIV:
                state_next = ST_NM_KRD;
            ST_NM_KRD:
                state_next = ST_NM_GO;
            ST_NM_GO:
                state_next = ST_NM_WAIT;
            ST_NM_WAIT:
                if (div_done)
                begin
                    if (k_reg != i_reg)
                        state_next = ST_NM_KRD;
                    else if (i_reg == n_m1)
                        state_next = ST_BS_RDB;
                    else
                        state_next = ST_EL_F;
                end
            ST_EL_F:
                state_next = ST_EL_FCAP;
            ST_EL_FCAP:
                state_next = ST_EL_RD;
            ST_EL_RD:
                state_next = ST_EL_M0;
            ST_EL_M0:
                state_next = ST_EL_M1;
            ST_EL_M1:
                state_next = ST_EL_WR;
            ST_EL_WR:
                if (k_reg != i_reg)
                    state_next = ST_EL_RD;
                else if (j_reg == n_m1)
                    state_next = ST_PV_RD;
                else
                    state_next = ST_EL_F;
            ST_BS_RDB:
                state_next = ST_BS_ACC;
            ST_BS_ACC:
                if (i_reg != n_m1)
                    state_next = ST_BS_RDJ;
                else if (i_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_BS_RDB;
            ST_BS_RDJ:
                state_next = ST_BS_M0;
            ST_BS_M0:
                state_next = ST_BS_M1;
            ST_BS_M1:
                state_next = ST_BS_UPD;
            ST_BS_UPD:
                if (j_reg != n_m1)
                    state_next = ST_BS_RDJ;
                else if (i_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_BS_RDB;
            ST_OUT:
                if (!out_stall && (i_reg == n_m1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        n_next    = n_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        sel_next  = sel_reg;
        best_next = best_reg;
        piv_next  = piv_reg;
        f_next    = f_reg;
        tmp_next  = tmp_reg;
        acc_next  = acc_reg;
        sing_next = sing_reg;
        sol_next  = sol_reg;
        a_we      = 1'b0;
        a_waddr   = mem_addr(CNT_W'(row), is_rhs ? CNT_W'(MAX_N) : CNT_W'(column));
        a_raddr   = mem_addr(j_reg, (k_reg == n_reg) ? CNT_W'(MAX_N) : k_reg);
        w_we      = 1'b0;
        w_waddr   = mem_addr(j_reg, k_reg);
        w_wdata   = a_rdata_reg;
        w_addr_a  = mem_addr(i_reg, k_reg);
        w_addr_b  = mem_addr(sel_reg, k_reg);
        div_start = 1'b0;
        ms_acc    = w_rdata_a_reg;
        ms_x      = f_reg;
        ms_y      = w_rdata_b_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (command == CMD_SOLVE)
                    begin
                        n_next    = n_eff;
                        sing_next = 1'b0;
                        j_next    = '0;
                        k_next    = '0;
                    end
                    else
                    begin
                        a_we = load_ok;
                    end
                end
            ST_CP_WR:
            begin
                w_we = 1'b1;
                if (k_reg == n_reg)
                begin
                    k_next = '0;
                    j_next = j_reg + 1'b1;
                    if (j_reg == n_m1)
                    begin
                        i_next    = '0;
                        j_next    = '0;
                        sel_next  = '0;
                        best_next = '0;
                    end
                end
                else
                    k_next = k_reg + 1'b1;
            end
            ST_PV_RD:
                w_addr_a = mem_addr(j_reg, i_reg);
            ST_PV_CMP:
            begin
                best_next = new_best;
                sel_next  = new_sel;
                k_next    = '0;
                if (j_reg == n_m1)
                begin
                    if (new_best == '0)
                    begin
                        sing_next = 1'b1;
                        i_next    = '0;
                    end
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_SW_W1:
            begin
                w_we     = 1'b1;
                w_waddr  = mem_addr(i_reg, k_reg);
                w_wdata  = w_rdata_b_reg;
                tmp_next = w_rdata_a_reg;
            end
            ST_SW_W2:
            begin
                w_we    = 1'b1;
                w_waddr = mem_addr(sel_reg, k_reg);
                w_wdata = tmp_reg;
                k_next  = k_reg + 1'b1;
            end
            ST_NM_RD:
                w_addr_a = mem_addr(i_reg, i_reg);
            ST_NM_PIV:
            begin
                piv_next = w_rdata_a_reg;
                k_next   = n_reg;
            end
            ST_NM_GO:
                div_start = 1'b1;
            ST_NM_WAIT:
                if (div_done)
                begin
                    w_we    = 1'b1;
                    w_waddr = mem_addr(i_reg, k_reg);
                    w_wdata = div_quo;
                    if (k_reg != i_reg)
                        k_next = k_reg - 1'b1;
                    else
                        j_next = i_reg + 1'b1;
                end
            ST_EL_F:
                w_addr_a = mem_addr(j_reg, i_reg);
            ST_EL_FCAP:
            begin
                f_next = w_rdata_a_reg;
                k_next = n_reg;
            end
            ST_EL_RD:
            begin
                w_addr_a = mem_addr(j_reg, k_reg);
                w_addr_b = mem_addr(i_reg, k_reg);
            end
            ST_EL_WR:
            begin
                w_we    = 1'b1;
                w_waddr = mem_addr(j_reg, k_reg);
                w_wdata = ms_res;
                if (k_reg != i_reg)
                    k_next = k_reg - 1'b1;
                else if (j_reg == n_m1)
                begin
                    i_next    = i_reg + 1'b1;
                    j_next    = i_reg + 1'b1;
                    sel_next  = i_reg + 1'b1;
                    best_next = '0;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_BS_RDB:
                w_addr_a = mem_addr(i_reg, n_reg);
            ST_BS_ACC:
            begin
                acc_next = w_rdata_a_reg;
                j_next   = i_reg + 1'b1;
                if (i_reg == n_m1)
                begin
                    sol_next[i_reg[ROW_W-1:0]] = w_rdata_a_reg;
                    if (i_reg != '0)
                        i_next = i_reg - 1'b1;
                end
            end
            ST_BS_RDJ:
                w_addr_a = mem_addr(i_reg, j_reg);
            ST_BS_M0:
            begin
                ms_acc = acc_reg;
                ms_x   = w_rdata_a_reg;
                ms_y   = sol_reg[sol_idx];
            end
            ST_BS_UPD:
            begin
                acc_next = ms_res;
                if (j_reg == n_m1)
                begin
                    sol_next[i_reg[ROW_W-1:0]] = ms_res;
                    if (i_reg != '0)
                        i_next = i_reg - 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_OUT:
                if (!out_stall && (i_reg != n_m1))
                    i_next = i_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = (state_reg == ST_OUT);
    assign index          = 3'(i_reg);
    assign solution_value = sing_reg ? '0 : sol_reg[sol_idx];
    assign singular       = sing_reg;
    assign last           = (i_reg == n_m1);

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_waddr] <= value;
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        w_rdata_a_reg <= w_mem[w_addr_a];
        w_rdata_b_reg <= w_mem[w_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= SIZE_W'(8);
            n_reg     <= CNT_W'(1);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sel_reg   <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            n_reg    <= n_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            sel_reg  <= sel_next;
            sing_reg <= sing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        piv_reg  <= piv_next;
        f_reg    <= f_next;
        tmp_reg  <= tmp_next;
        acc_reg  <= acc_next;
        sol_reg  <= sol_next;
    end

endmodule

// ===== hw/rtl/gpps_div.sv =====
// Iterative restoring divider: sat32((num << FRAC_BITS) / den), truncated toward zero.
// One quotient bit per cycle. Depends on gpps_pkg.
module gpps_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [gpps_pkg::DATA_W-1:0]   num,
    input  logic signed [gpps_pkg::DATA_W-1:0]   den,
    output logic                                 done,
    output logic signed [gpps_pkg::DATA_W-1:0]   quo
);
    import gpps_pkg::*;

    logic [DVD_W-1:0]  shift_reg, shift_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W:0]   num_mag;
    logic [DATA_W:0]   den_mag;

    always_comb
    begin
        num_mag    = mag(num);
        den_mag    = mag(den);
        trial      = {rem_reg, shift_reg[DVD_W-1]};
        ge         = trial >= {1'b0, den_reg};
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = {num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_next   = '0;
            den_next   = den_mag[DATA_W-1:0];
            neg_next   = num[DATA_W-1] ^ den[DATA_W-1];
            cnt_next   = DCNT_W'(DVD_W);
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next   = ge ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            shift_next = {shift_reg[DVD_W-2:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (shift_reg > DVD_W'({1'b0, {(DATA_W-1){1'b1}}}))
                quo = {1'b0, {(DATA_W-1){1'b1}}};
            else
                quo = shift_reg[DATA_W-1:0];
        end
        else
        begin
            if (shift_reg > DVD_W'({1'b1, {(DATA_W-1){1'b0}}}))
                quo = {1'b1, {(DATA_W-1){1'b0}}};
            else
                quo = -shift_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
    end

endmodule

// ===== hw/rtl/gpps_msub.sv =====
// Two-stage multiply-subtract unit: sat32(acc - trunc((x * y) / 2^FRAC_BITS)).
// The product and acc are registered, then the saturated result is registered. Depends on gpps_pkg.
module gpps_msub (
    input  logic                                 clk,
    input  logic signed [gpps_pkg::DATA_W-1:0]   acc,
    input  logic signed [gpps_pkg::DATA_W-1:0]   x,
    input  logic signed [gpps_pkg::DATA_W-1:0]   y,
    output logic signed [gpps_pkg::DATA_W-1:0]   result
);
    import gpps_pkg::*;

    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0]   acc_reg;
    logic signed [DATA_W-1:0]   res_reg, res_next;
    logic signed [2*DATA_W-1:0] adj;
    logic signed [2*DATA_W-1:0] q;
    logic signed [2*DATA_W-1:0] diff;

    always_comb
    begin
        prod_next = x * y;
        if (prod_reg < 0)
            adj = prod_reg + (2*DATA_W)'((64'd1 << FRAC_BITS) - 64'd1);
        else
            adj = prod_reg;
        q    = adj >>> FRAC_BITS;
        diff = (2*DATA_W)'(acc_reg) - q;
        if (diff > $signed((2*DATA_W)'({1'b0, {(DATA_W-1){1'b1}}})))
            res_next = {1'b0, {(DATA_W-1){1'b1}}};
        else if (diff < $signed({{(DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
            res_next = {1'b1, {(DATA_W-1){1'b0}}};
        else
            res_next = diff[DATA_W-1:0];
    end

    assign result = res_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc;
        res_reg  <= res_next;
    end

endmodule
